// ===== hdl/clbn_pkg.sv =====
// Package for the periodic cell-list binning block.
// Holds the item field widths, the operation, status and register index codes.
// No dependencies.
`timescale 1ns / 1ps

package clbn_pkg;

    // Item field widths fixed by the stream format.
    localparam int ID_BITS    = 12;
    localparam int COORD_BITS = 16;
    localparam int NCELL_BITS = 5;
    localparam int LEN_BITS   = 16;
    localparam int FUNC_BITS  = 2;
    localparam int STAT_BITS  = 2;
    localparam int CFG_IDX_BITS = 3;

    // Operation codes carried in the input tuser.
    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    // Status codes carried in the result.
    localparam logic [STAT_BITS-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_BITS-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_BITS-1:0] STAT_TRUNC = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_CELLS_X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CELLS_Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CELLS_Z = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEN_X   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEN_Y   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEN_Z   = 3'd5;

endpackage

// ===== hdl/cell_list_binning_neighbors.sv =====
// Periodic 3-D cell list: clear, insert and 27-cell neighbor query.
// Depends on clbn_pkg for field widths and codes.
// Input item: tuser = func; tdata = particle_id, pos_x, pos_y, pos_z (low bits up).
// Result item: tdata = neighbor_id, id_valid, status (low bits up); tlast = last.
// Every input item gives one or more result items, the final one with tlast.
// Insert and query first bin the position: three bit-serial dividers (one per
// axis) produce the quotient bit by bit and fold it modulo the cell count.
// Insert then reads the cell count, then writes the member and the count.
// A query visits 27 cells, reading the count of each cell and then each
// stored id of that cell from the member memory.
// Clear and reset run a sweep through all 2**(3*clog2(MAX_CELLS_PER_DIM))
// count memory entries (4096 at the default), one entry a cycle; no input item
// is taken during the sweep, configuration writes are.
// One item is worked at a time; s_axis_tready is high only when idle.
// A result waits in the output register while m_axis_tready is low, and the
// block stalls at the next result until it is taken.
`timescale 1ns / 1ps

module cell_list_binning_neighbors #(
    parameter int MAX_CELLS_PER_DIM = 16,
    parameter int CELL_CAPACITY     = 8,
    parameter int MAX_NEIGHBORS     = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [clbn_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [clbn_pkg::LEN_BITS-1:0]     i_cfg_data,
    // Input items.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: particle_id[11:0], pos_x[27:12], pos_y[43:28], pos_z[59:44], zero pad.
    input  logic [63:0] s_axis_tdata,
    // tuser: func[1:0].
    input  logic [clbn_pkg::FUNC_BITS-1:0] s_axis_tuser,
    // Result items.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: neighbor_id[11:0], id_valid[12], status[14:13], zero pad[15].
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import clbn_pkg::*;

    localparam int CB    = $clog2(MAX_CELLS_PER_DIM);
    localparam int NB    = CB + 1;
    localparam int CIDX  = 3 * CB;
    localparam int NCELL = 1 << CIDX;
    localparam int CNTW  = $clog2(CELL_CAPACITY + 1);
    localparam int SB    = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;
    localparam int MADR  = CIDX + SB;
    localparam int NFW   = $clog2(MAX_NEIGHBORS + 1);
    localparam int STW   = $clog2(COORD_BITS);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DIV, S_INS_RD, S_INS_CHK,
        S_Q_CRD, S_Q_CNT, S_Q_MRD, S_Q_MDAT, S_RESP
    } t_state;

    // Registers.
    t_state                  r_state, n_state;
    logic [NCELL_BITS-1:0]   r_cells [3];
    logic [LEN_BITS-1:0]     r_len   [3];
    logic [CIDX-1:0]         r_clr_addr, n_clr_addr;
    t_func                   r_func, n_func;
    logic [ID_BITS-1:0]      r_pid, n_pid;
    logic [COORD_BITS-1:0]   r_dvd [3], n_dvd [3];
    logic [COORD_BITS-1:0]   r_rem [3], n_rem [3];
    logic [CB-1:0]           r_cmod [3], n_cmod [3];
    logic [STW-1:0]          r_step, n_step;
    logic [1:0]              r_dlt [3], n_dlt [3];
    logic [CNTW-1:0]         r_n, n_n;
    logic [CNTW-1:0]         r_i, n_i;
    logic [NFW-1:0]          r_nfound, n_nfound;
    logic                    r_ovf, n_ovf;
    logic                    r_have_pend, n_have_pend;
    logic [ID_BITS-1:0]      r_pend, n_pend;
    logic [ID_BITS-1:0]      r_rid, n_rid;
    logic                    r_rvalid, n_rvalid;
    logic [STAT_BITS-1:0]    r_rstat, n_rstat;
    logic                    r_out_valid, n_out_valid;
    logic [ID_BITS-1:0]      r_out_id, n_out_id;
    logic                    r_out_idv, n_out_idv;
    logic [STAT_BITS-1:0]    r_out_stat, n_out_stat;
    logic                    r_out_last, n_out_last;

    // Memories and their ports.
    logic [CNTW-1:0]    cnt_mem [NCELL];
    logic [ID_BITS-1:0] mbr_mem [NCELL << SB];
    logic [CNTW-1:0]    r_cnt_rd;
    logic [ID_BITS-1:0] r_mbr_rd;
    logic               cnt_re, cnt_we, mbr_re, mbr_we;
    logic [CIDX-1:0]    cnt_raddr, cnt_waddr;
    logic [CNTW-1:0]    cnt_wdata;
    logic [MADR-1:0]    mbr_raddr, mbr_waddr;

    logic [NB-1:0]      n_eff [3];
    logic [LEN_BITS-1:0] len_eff [3];
    logic [CB-1:0]      qc [3];
    logic [CIDX-1:0]    ins_cell, q_cell;
    logic               out_free, last_cell, in_acc;
    logic [COORD_BITS:0] t_div;
    logic [NB-1:0]      m2;
    logic [NB-1:0]      qn;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_stat, r_out_idv, r_out_id};
    assign m_axis_tlast  = r_out_last;

    // Effective cell counts and lengths, and wrapped neighbor cell per axis.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_cells[k] == '0) begin
                n_eff[k] = NB'(1);
            end else if (32'(r_cells[k]) > MAX_CELLS_PER_DIM) begin
                n_eff[k] = NB'(MAX_CELLS_PER_DIM);
            end else begin
                n_eff[k] = NB'(r_cells[k]);
            end
            len_eff[k] = (r_len[k] == '0) ? LEN_BITS'(1) : r_len[k];
            case (r_dlt[k])
                2'd0: begin
                    qn = (r_cmod[k] == '0) ? n_eff[k] - NB'(1) : {1'b0, r_cmod[k]} - NB'(1);
                end
                2'd2: begin
                    qn = ({1'b0, r_cmod[k]} + NB'(1) == n_eff[k]) ? '0
                                                                   : {1'b0, r_cmod[k]} + NB'(1);
                end
                default: begin
                    qn = {1'b0, r_cmod[k]};
                end
            endcase
            qc[k] = qn[CB-1:0];
        end
    end

    assign ins_cell  = {r_cmod[0], r_cmod[1], r_cmod[2]};
    assign q_cell    = {qc[0], qc[1], qc[2]};
    assign last_cell = (r_dlt[0] == 2'd2) && (r_dlt[1] == 2'd2) && (r_dlt[2] == 2'd2);

    // Memory port control.
    always_comb begin
        cnt_re    = (r_state == S_INS_RD) || (r_state == S_Q_CRD);
        cnt_raddr = (r_state == S_INS_RD) ? ins_cell : q_cell;
        cnt_we    = 1'b0;
        cnt_waddr = r_clr_addr;
        cnt_wdata = '0;
        mbr_re    = (r_state == S_Q_MRD);
        mbr_raddr = {q_cell, r_i[SB-1:0]};
        mbr_we    = 1'b0;
        mbr_waddr = {ins_cell, r_cnt_rd[SB-1:0]};
        if (r_state == S_CLR) begin
            cnt_we = 1'b1;
        end else if (r_state == S_INS_CHK && out_free
                     && 32'(r_cnt_rd) < CELL_CAPACITY) begin
            cnt_we    = 1'b1;
            cnt_waddr = ins_cell;
            cnt_wdata = r_cnt_rd + CNTW'(1);
            mbr_we    = 1'b1;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_func      = r_func;
        n_pid       = r_pid;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_cmod      = r_cmod;
        n_step      = r_step;
        n_dlt       = r_dlt;
        n_n         = r_n;
        n_i         = r_i;
        n_nfound    = r_nfound;
        n_ovf       = r_ovf;
        n_have_pend = r_have_pend;
        n_pend      = r_pend;
        n_rid       = r_rid;
        n_rvalid    = r_rvalid;
        n_rstat     = r_rstat;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_id    = r_out_id;
        n_out_idv   = r_out_idv;
        n_out_stat  = r_out_stat;
        n_out_last  = r_out_last;
        t_div       = '0;
        m2          = '0;

        case (r_state)
            // Count memory sweep after reset and on clear.
            S_CLR: begin
                n_clr_addr = r_clr_addr + CIDX'(1);
                if (r_clr_addr == '1) begin
                    n_state = (r_func == FUNC_CLEAR) ? S_RESP : S_IDLE;
                end
            end
            S_IDLE: begin
                n_rid    = '0;
                n_rvalid = 1'b0;
                n_rstat  = STAT_OK;
                if (in_acc) begin
                    n_func   = t_func'(s_axis_tuser);
                    n_pid    = s_axis_tdata[ID_BITS-1:0];
                    n_dvd[0] = s_axis_tdata[ID_BITS +: COORD_BITS];
                    n_dvd[1] = s_axis_tdata[ID_BITS + COORD_BITS +: COORD_BITS];
                    n_dvd[2] = s_axis_tdata[ID_BITS + 2*COORD_BITS +: COORD_BITS];
                    for (int k = 0; k < 3; k++) begin
                        n_rem[k]  = '0;
                        n_cmod[k] = '0;
                    end
                    n_step = '0;
                    case (t_func'(s_axis_tuser))
                        FUNC_CLEAR: begin
                            n_clr_addr = '0;
                            n_state    = S_CLR;
                        end
                        FUNC_INSERT, FUNC_QUERY: begin
                            n_state = S_DIV;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            // One quotient bit per axis per cycle, folded modulo the cell count.
            S_DIV: begin
                for (int k = 0; k < 3; k++) begin
                    t_div    = {r_rem[k], r_dvd[k][COORD_BITS-1]};
                    n_dvd[k] = {r_dvd[k][COORD_BITS-2:0], 1'b0};
                    if (t_div >= {1'b0, len_eff[k]}) begin
                        n_rem[k] = COORD_BITS'(t_div - {1'b0, len_eff[k]});
                        m2       = {r_cmod[k], 1'b1};
                    end else begin
                        n_rem[k] = t_div[COORD_BITS-1:0];
                        m2       = {r_cmod[k], 1'b0};
                    end
                    n_cmod[k] = (m2 >= n_eff[k]) ? CB'(m2 - n_eff[k]) : CB'(m2);
                end
                n_step = r_step + STW'(1);
                if (32'(r_step) == COORD_BITS - 1) begin
                    for (int k = 0; k < 3; k++) begin
                        n_dlt[k] = 2'd0;
                    end
                    n_nfound    = '0;
                    n_ovf       = 1'b0;
                    n_have_pend = 1'b0;
                    n_state     = (r_func == FUNC_INSERT) ? S_INS_RD : S_Q_CRD;
                end
            end
            S_INS_RD: begin
                n_state = S_INS_CHK;
            end
            // Store the id when the cell has room, then report.
            S_INS_CHK: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_id    = '0;
                    n_out_idv   = 1'b0;
                    n_out_last  = 1'b1;
                    n_out_stat  = (32'(r_cnt_rd) < CELL_CAPACITY) ? STAT_OK : STAT_FULL;
                    n_state     = S_IDLE;
                end
            end
            S_Q_CRD: begin
                n_state = S_Q_CNT;
            end
            // Count of the visited cell is here.
            S_Q_CNT: begin
                n_n = (32'(r_cnt_rd) > CELL_CAPACITY) ? CNTW'(CELL_CAPACITY) : r_cnt_rd;
                n_i = '0;
                if (r_cnt_rd == '0 || r_nfound == NFW'(MAX_NEIGHBORS)) begin
                    if (r_cnt_rd != '0) begin
                        n_ovf = 1'b1;
                    end
                    n_state = S_Q_CRD;
                    if (r_dlt[2] != 2'd2) begin
                        n_dlt[2] = r_dlt[2] + 2'd1;
                    end else begin
                        n_dlt[2] = 2'd0;
                        if (r_dlt[1] != 2'd2) begin
                            n_dlt[1] = r_dlt[1] + 2'd1;
                        end else begin
                            n_dlt[1] = 2'd0;
                            n_dlt[0] = r_dlt[0] + 2'd1;
                        end
                    end
                    if (last_cell) begin
                        n_state  = S_RESP;
                        n_rid    = r_have_pend ? r_pend : '0;
                        n_rvalid = r_have_pend;
                        n_rstat  = ((r_ovf || r_cnt_rd != '0) && r_have_pend) ? STAT_TRUNC
                                                                               : STAT_OK;
                    end
                end else begin
                    n_state = S_Q_MRD;
                end
            end
            S_Q_MRD: begin
                n_state = S_Q_MDAT;
            end
            // Member id is here; the held id goes out once a newer one exists.
            S_Q_MDAT: begin
                if (!r_have_pend || out_free) begin
                    if (r_have_pend) begin
                        n_out_valid = 1'b1;
                        n_out_id    = r_pend;
                        n_out_idv   = 1'b1;
                        n_out_stat  = STAT_OK;
                        n_out_last  = 1'b0;
                    end
                    n_pend      = r_mbr_rd;
                    n_have_pend = 1'b1;
                    n_nfound    = r_nfound + NFW'(1);
                    n_i         = r_i + CNTW'(1);
                    if (r_i + CNTW'(1) < r_n && r_nfound != NFW'(MAX_NEIGHBORS - 1)) begin
                        n_state = S_Q_MRD;
                    end else begin
                        if (r_i + CNTW'(1) < r_n) begin
                            n_ovf = 1'b1;
                        end
                        n_state = S_Q_CRD;
                        if (r_dlt[2] != 2'd2) begin
                            n_dlt[2] = r_dlt[2] + 2'd1;
                        end else begin
                            n_dlt[2] = 2'd0;
                            if (r_dlt[1] != 2'd2) begin
                                n_dlt[1] = r_dlt[1] + 2'd1;
                            end else begin
                                n_dlt[1] = 2'd0;
                                n_dlt[0] = r_dlt[0] + 2'd1;
                            end
                        end
                        if (last_cell) begin
                            n_state  = S_RESP;
                            n_rid    = r_mbr_rd;
                            n_rvalid = 1'b1;
                            n_rstat  = (r_ovf || r_i + CNTW'(1) < r_n) ? STAT_TRUNC : STAT_OK;
                        end
                    end
                end
            end
            // Final result of the item.
            S_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_id    = r_rid;
                    n_out_idv   = r_rvalid;
                    n_out_stat  = r_rstat;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_func      <= FUNC_NONE;
            r_out_valid <= 1'b0;
            r_have_pend <= 1'b0;
            r_nfound    <= '0;
            r_ovf       <= 1'b0;
            r_step      <= '0;
            r_cells[0]  <= NCELL_BITS'(4);
            r_cells[1]  <= NCELL_BITS'(4);
            r_cells[2]  <= NCELL_BITS'(4);
            r_len[0]    <= LEN_BITS'(16384);
            r_len[1]    <= LEN_BITS'(16384);
            r_len[2]    <= LEN_BITS'(16384);
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_func      <= n_func;
            r_out_valid <= n_out_valid;
            r_have_pend <= n_have_pend;
            r_nfound    <= n_nfound;
            r_ovf       <= n_ovf;
            r_step      <= n_step;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CELLS_X: r_cells[0] <= i_cfg_data[NCELL_BITS-1:0];
                    CFG_CELLS_Y: r_cells[1] <= i_cfg_data[NCELL_BITS-1:0];
                    CFG_CELLS_Z: r_cells[2] <= i_cfg_data[NCELL_BITS-1:0];
                    CFG_LEN_X:   r_len[0]   <= i_cfg_data;
                    CFG_LEN_Y:   r_len[1]   <= i_cfg_data;
                    CFG_LEN_Z:   r_len[2]   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        r_pid      <= n_pid;
        r_dvd      <= n_dvd;
        r_rem      <= n_rem;
        r_cmod     <= n_cmod;
        r_dlt      <= n_dlt;
        r_n        <= n_n;
        r_i        <= n_i;
        r_pend     <= n_pend;
        r_rid      <= n_rid;
        r_rvalid   <= n_rvalid;
        r_rstat    <= n_rstat;
        r_out_id   <= n_out_id;
        r_out_idv  <= n_out_idv;
        r_out_stat <= n_out_stat;
        r_out_last <= n_out_last;
    end

    // Per-cell fill counts.
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re) begin
            r_cnt_rd <= cnt_mem[cnt_raddr];
        end
    end

    // Stored ids, addressed by cell and slot.
    always_ff @(posedge i_clk) begin
        if (mbr_we) begin
            mbr_mem[mbr_waddr] <= r_pid;
        end
        if (mbr_re) begin
            r_mbr_rd <= mbr_mem[mbr_raddr];
        end
    end

    // A cell count never goes past the capacity.
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_we |-> 32'(cnt_wdata) <= CELL_CAPACITY)
        else $error("cell count written above capacity");

    // The found-id count never passes the neighbor limit.
    a_nfound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_nfound) <= MAX_NEIGHBORS)
        else $error("neighbor count past limit");

    // Reset always starts the clearing sweep.
    a_rst_clr: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == S_CLR) && (r_clr_addr == '0))
        else $error("reset did not start the clear sweep");

    // A held id exists whenever a query has found anything.
    a_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_Q_CRD && r_nfound != '0) |-> r_have_pend)
        else $error("found ids without a held id");

endmodule
